// ===== rtl/sync_crc_frame_extractor_core_defines.svh =====
// ---------------------------------------------------------------------------
// Sync CRC frame extractor - assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SYNC_CRC_FRAME_EXTRACTOR_CORE_DEFINES_SVH
`define SYNC_CRC_FRAME_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication
`define SCFE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCFE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/scfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Sync CRC frame extractor - package
// Result kinds, register indexes, controller/datapath interface, CRC step.
// ---------------------------------------------------------------------------
package scfe_pkg;

	localparam int BYTE_INDEX_W = 6;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ID      = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hFE;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'hEE;
	localparam logic [7:0]  MAX_ID_RST      = 8'd15;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'h1021;

	typedef enum logic [1:0] {
		KIND_FRAME_BYTE = 2'd0,
		KIND_CRC_ERR    = 2'd1,
		KIND_BAD_ID     = 2'd2
	} kind_t;

	typedef struct packed {
		logic  load_in;    // append input byte
		logic  drop;       // drop oldest byte
		logic  crc_start;  // init CRC, clear counter, capture id
		logic  crc_step;   // rotate window, fold byte into CRC (all but the last two bytes)
		logic  cnt_clr;
		logic  emit_byte;  // emit front byte, rotate window
		logic  out_err;    // emit error result
		kind_t err_kind;
		logic  clear_fill;
	} cmd_t;

	typedef struct packed {
		logic fill_lt2;
		logic fill_full;
		logic hdr_front;
		logic cnt_last;
		logic crc_ok;
		logic id_ok;
		logic out_free;
	} sts_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/scfe_datapath.sv =====
// ---------------------------------------------------------------------------
// Sync CRC frame extractor - datapath
// Byte window shift line, fill count, CRC unit, config registers, result register.
// ---------------------------------------------------------------------------
`include "sync_crc_frame_extractor_core_defines.svh"

module scfe_datapath
	import scfe_pkg::*;
#(
	parameter int FRAME_BYTES = 16,
	parameter int ID_POSITION = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             s_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_wdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [23:0]            m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast,
	input  cmd_t                   cmd,
	output sts_t                   sts
);

	localparam int IdxW  = $clog2(FRAME_BYTES);
	localparam int CntW  = $clog2(FRAME_BYTES + 1);
	localparam int IdIdx = ID_POSITION % FRAME_BYTES;

	logic [7:0]              w_q [FRAME_BYTES];
	logic [CntW-1:0]         fill_q;
	logic [CntW-1:0]         cnt_q;
	logic [15:0]             crc_q;
	logic [7:0]              id_q;
	logic [7:0]              sync_first_q;
	logic [7:0]              sync_second_q;
	logic [7:0]              max_id_q;
	logic                    m_tvalid_q;
	kind_t                   kind_q;
	logic [7:0]              dev_q;
	logic [BYTE_INDEX_W-1:0] idx_q;
	logic [7:0]              byte_q;
	logic                    last_q;
	logic                    rotate;

	assign rotate = cmd.crc_step | cmd.emit_byte;

	// window: shift line, written at the fill position
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			w_q[fill_q[IdxW-1:0]] <= s_tdata;
		end else if (cmd.drop) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
		end else if (rotate) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[FRAME_BYTES-1] <= w_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_id_q      <= MAX_ID_RST;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cmd.clear_fill) begin
				fill_q <= '0;
			end else if (cmd.load_in) begin
				fill_q <= fill_q + CntW'(1);
			end else if (cmd.drop) begin
				fill_q <= fill_q - CntW'(1);
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
					REG_SYNC_SECOND: sync_second_q <= cfg_wdata;
					REG_MAX_ID:      max_id_q      <= cfg_wdata;
					default: ;
				endcase
			end

			if (cmd.emit_byte || cmd.out_err) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// CRC walk: window rotates once through position 0
	always_ff @(posedge clk) begin
		if (cmd.crc_start) begin
			crc_q <= CRC_INIT;
			id_q  <= w_q[IdIdx];
		end else if (cmd.crc_step && cnt_q < CntW'(FRAME_BYTES - 2)) begin
			crc_q <= crc_byte(crc_q, w_q[0]);
		end

		if (cmd.crc_start || cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (rotate) begin
			cnt_q <= cnt_q + CntW'(1);
		end

		if (cmd.emit_byte) begin
			kind_q <= KIND_FRAME_BYTE;
			dev_q  <= id_q;
			idx_q  <= BYTE_INDEX_W'(cnt_q);
			byte_q <= w_q[0];
			last_q <= sts.cnt_last;
		end else if (cmd.out_err) begin
			kind_q <= cmd.err_kind;
			dev_q  <= id_q;
			idx_q  <= '0;
			byte_q <= '0;
			last_q <= 1'b1;
		end
	end

	always_comb begin
		sts.fill_lt2  = fill_q < CntW'(2);
		sts.fill_full = fill_q == CntW'(FRAME_BYTES);
		sts.hdr_front = (w_q[0] == sync_first_q) && (w_q[1] == sync_second_q);
		sts.cnt_last  = cnt_q == CntW'(FRAME_BYTES - 1);
		// received CRC is little-endian in the last two bytes
		sts.crc_ok    = crc_q == {w_q[FRAME_BYTES-1], w_q[FRAME_BYTES-2]};
		sts.id_ok     = id_q <= max_id_q;
		sts.out_free  = !m_tvalid_q || m_tready;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, byte_q, idx_q, dev_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	`SCFE_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= CntW'(FRAME_BYTES), "fill count overflow")
	`SCFE_ASSERT_IMP(a_load_room, cmd.load_in, fill_q < CntW'(FRAME_BYTES), "append into full window")
	`SCFE_ASSERT_IMP(a_frame_last, m_tvalid_q && kind_q == KIND_FRAME_BYTE && last_q,
		idx_q == BYTE_INDEX_W'(FRAME_BYTES - 1), "frame ends before its last byte")

endmodule

// ===== rtl/scfe_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sync CRC frame extractor - controller
// Sequences accept, header search, CRC walk, check and frame emission.
// ---------------------------------------------------------------------------
`include "sync_crc_frame_extractor_core_defines.svh"

module scfe_ctrl
	import scfe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CRC,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.fill_lt2) begin
					state_d = ST_IDLE;
				end else if (sts.hdr_front) begin
					if (!sts.fill_full) begin
						state_d = ST_IDLE;
					end else begin
						cmd.crc_start = 1'b1;
						state_d       = ST_CRC;
					end
				end else begin
					// no header at front: slide by one byte
					cmd.drop = 1'b1;
				end
			end
			ST_CRC: begin
				cmd.crc_step = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.crc_ok && sts.id_ok) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_EMIT;
				end else if (sts.out_free) begin
					cmd.out_err = 1'b1;
					if (sts.crc_ok) begin
						cmd.err_kind   = KIND_BAD_ID;
						cmd.clear_fill = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cmd.err_kind = KIND_CRC_ERR;
						cmd.drop     = 1'b1;
						state_d      = ST_SCAN;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					if (sts.cnt_last) begin
						cmd.clear_fill = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SCFE_ASSERT_IMP(a_out_free, cmd.emit_byte || cmd.out_err, sts.out_free,
		"result loaded over a waiting one")
	`SCFE_ASSERT_IMP(a_drop_nonempty, cmd.drop, !sts.fill_lt2, "drop from short window")
	`SCFE_ASSERT_NXT(a_frame_done, cmd.emit_byte && sts.cnt_last, state_q == ST_IDLE,
		"frame emission does not return to idle")

endmodule

// ===== rtl/sync_crc_frame_extractor_core.sv =====
// ---------------------------------------------------------------------------
// Sync CRC frame extractor - top level
// Two-byte sync, fixed-length deframer with CRC-16/CCITT-FALSE check.
// ---------------------------------------------------------------------------
// Channel   Dir  Signals                        Contents
// s_*       in   tvalid/tready/tdata[7:0]       rx_byte
// m_*       out  tvalid/tready/tdata/tuser/tlast frame bytes and error reports
// cfg_*     in   we/index[1:0]/wdata[7:0]       sync_first, sync_second, max id
//
// A request is accepted in IDLE and then scanned; during header search each byte that
// does not start a header is slid off the front (up to FRAME_BYTES-1 bytes), one byte
// per step of the single-step shift line. A full window with a header adds a CRC walk
// (one byte per cycle), a check and, for a good frame, emission of FRAME_BYTES bytes;
// a CRC error drops the front byte and returns to header search.
// Emission holds while the result register is full.
// Reset is asynchronous, active low; the window needs no clearing.
// ---------------------------------------------------------------------------
module sync_crc_frame_extractor_core
	import scfe_pkg::*;
#(
	parameter int FRAME_BYTES = 16,
	parameter int ID_POSITION = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,    // [7:0] rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [23:0]            m_tdata,    // [7:0] node_id, [13:8] byte_index,
	                                           // [21:14] frame_byte, [23:22] zero
	output logic [1:0]             m_tuser,    // [1:0] kind
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	scfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scfe_datapath #(
		.FRAME_BYTES (FRAME_BYTES),
		.ID_POSITION (ID_POSITION)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
